/* hdl/fpfir_pkg.sv */
// Shared constants and types for the fixed-point FIR filter.
`timescale 1ns / 1ps

package fpfir_pkg;

   // Sizing of the filter
   localparam int MAX_TAPS        = 64;
   localparam int SAMPLE_BITS     = 16;
   localparam int COEF_BITS       = 15;
   localparam int OUT_BITS        = 23;
   localparam int COEF_INDEX_BITS = 6;

   localparam int IDX_BITS  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TAP_BITS  = $clog2(MAX_TAPS + 1);
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + TAP_BITS;

   // Configuration registers
   localparam int TAPS_CFG_BITS  = 7;
   localparam int SHIFT_CFG_BITS = 5;
   localparam int CSR_DATA_BITS  = 7;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TAPS_IN_USE  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RESULT_SHIFT = 1'd1;

   localparam logic [TAPS_CFG_BITS-1:0]  TAPS_RESET  = 7'd49;
   localparam logic [SHIFT_CFG_BITS-1:0] SHIFT_RESET = 5'd13;

   // Request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   // Controls for one tap cell
   typedef struct packed {
      logic shift;    // take the left neighbor's sample
      logic rotate;   // take the right neighbor's sample and coefficient
      logic coef_we;  // load a new coefficient
   } cell_ctl_type;

   // Controls for the multiply-accumulate unit
   typedef struct packed {
      logic clear;    // start a new sum
      logic tap_en;   // the pair at the head of the ring counts
   } mac_ctl_type;

endpackage

/* hdl/fpfir_if.sv */
// Request and response channel interfaces of the FIR filter.
`timescale 1ns / 1ps

interface fpfir_req_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        kind;
   logic signed [fpfir_pkg::SAMPLE_BITS-1:0]    sample_value;
   logic        [fpfir_pkg::COEF_INDEX_BITS-1:0] coef_index;
   logic signed [fpfir_pkg::COEF_BITS-1:0]      coef_value;

   modport source (output valid, kind, sample_value, coef_index, coef_value, input ready);
   modport sink   (input valid, kind, sample_value, coef_index, coef_value, output ready);
endinterface

interface fpfir_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [fpfir_pkg::OUT_BITS-1:0]    filtered;

   modport source (output valid, filtered, input ready);
   modport sink   (input valid, filtered, output ready);
endinterface

/* hdl/fpfir_tap_cell.sv */
// One tap cell: holds one history sample and one coefficient.
`timescale 1ns / 1ps

module fpfir_tap_cell (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fpfir_pkg::cell_ctl_type                  ctl,
   input  logic signed [fpfir_pkg::SAMPLE_BITS-1:0] left_sample,
   input  logic signed [fpfir_pkg::SAMPLE_BITS-1:0] right_sample,
   input  logic signed [fpfir_pkg::COEF_BITS-1:0]   right_coef,
   input  logic signed [fpfir_pkg::COEF_BITS-1:0]   new_coef,
   output logic signed [fpfir_pkg::SAMPLE_BITS-1:0] sample_out,
   output logic signed [fpfir_pkg::COEF_BITS-1:0]   coef_out
);

   logic signed [fpfir_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [fpfir_pkg::COEF_BITS-1:0]   coef_ff, coef_in;

   // Shift on a new sample, rotate during the sum, or load a coefficient
   always_comb begin
      sample_in = sample_ff;
      coef_in   = coef_ff;
      priority if (ctl.shift) begin
         sample_in = left_sample;
      end else if (ctl.rotate) begin
         sample_in = right_sample;
         coef_in   = right_coef;
      end else if (ctl.coef_we) begin
         coef_in = new_coef;
      end else begin
         // hold both values
         sample_in = sample_ff;
         coef_in   = coef_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         coef_ff   <= '0;
      end else begin
         sample_ff <= sample_in;
         coef_ff   <= coef_in;
      end
   end

   assign sample_out = sample_ff;
   assign coef_out   = coef_ff;

endmodule

/* hdl/fpfir_mac.sv */
// Multiply-accumulate unit with floor shift and saturation of the sum.
`timescale 1ns / 1ps

module fpfir_mac (
   input  logic                                        clock,
   input  logic                                        reset,
   input  fpfir_pkg::mac_ctl_type                      ctl,
   input  logic signed [fpfir_pkg::SAMPLE_BITS-1:0]    sample,
   input  logic signed [fpfir_pkg::COEF_BITS-1:0]      coef,
   input  logic        [fpfir_pkg::SHIFT_CFG_BITS-1:0] shift_amount,
   output logic signed [fpfir_pkg::OUT_BITS-1:0]       result
);

   localparam logic signed [fpfir_pkg::ACC_BITS-1:0] SAT_HI =
      fpfir_pkg::ACC_BITS'((2 ** (fpfir_pkg::OUT_BITS - 1)) - 1);
   localparam logic signed [fpfir_pkg::ACC_BITS-1:0] SAT_LO =
      fpfir_pkg::ACC_BITS'(-(2 ** (fpfir_pkg::OUT_BITS - 1)));

   logic signed [fpfir_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic                                   prod_en_ff, prod_en_in;
   logic signed [fpfir_pkg::ACC_BITS-1:0]  acc_ff, acc_in;
   logic signed [fpfir_pkg::ACC_BITS-1:0]  shifted;

   // Register the product of the pair at the head of the ring
   always_comb begin
      prod_in    = fpfir_pkg::PROD_BITS'(sample * coef);
      prod_en_in = ctl.tap_en && !ctl.clear;
   end

   // Add the registered product into the sum
   always_comb begin
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_en_ff) begin
         acc_in = acc_ff + fpfir_pkg::ACC_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_en_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         prod_en_ff <= prod_en_in;
         acc_ff     <= acc_in;
      end
      prod_ff <= prod_in;
   end

   // Floor shift, then clamp to the output range
   always_comb begin
      shifted = acc_ff >>> shift_amount;
      if (shifted > SAT_HI) begin
         result = fpfir_pkg::OUT_BITS'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         result = fpfir_pkg::OUT_BITS'(SAT_LO);
      end else begin
         result = fpfir_pkg::OUT_BITS'(shifted);
      end
   end

endmodule

/* hdl/fixed_point_fir_filter.sv */
// Top level of the fixed-point FIR filter: tap ring, sequencer and response register.
`timescale 1ns / 1ps

// A coefficient request gives no response. A sample request shifts the sample into
// a ring of MAX_TAPS tap cells, then the ring rotates once around, one cell per cycle,
// past a single multiply-accumulate unit at its head: that one multiplier sets the rate.
// Whatever taps_in_use says, the sequencer passes through RUN, DRAIN and FINAL before
// the next request is taken, and waits in FINAL until the response register is free.
// The response register holds one finished result while the next request is taken.
// The user must write configuration only while the filter is idle; the block itself
// does not enforce this.

module fixed_point_fir_filter (
   input  logic                                     clock,
   input  logic                                     reset,
   fpfir_req_if.sink                                req_bus,
   fpfir_rsp_if.source                              rsp_bus,
   input  logic                                     csr_we,
   input  logic [fpfir_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [fpfir_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FINAL = 2'd3;

   localparam logic [fpfir_pkg::IDX_BITS-1:0] LAST_IDX =
      fpfir_pkg::IDX_BITS'(fpfir_pkg::MAX_TAPS - 1);

   logic [1:0]                              state_ff, state_in;
   logic [fpfir_pkg::IDX_BITS-1:0]          cnt_ff, cnt_in;
   logic [fpfir_pkg::TAPS_CFG_BITS-1:0]     taps_ff, taps_in;
   logic [fpfir_pkg::SHIFT_CFG_BITS-1:0]    shift_ff, shift_in;
   logic [fpfir_pkg::TAP_BITS-1:0]          taps_eff;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [fpfir_pkg::OUT_BITS-1:0]   rsp_data_ff, rsp_data_in;

   logic                                    req_fire, sample_fire, coef_fire, out_free;
   logic signed [fpfir_pkg::OUT_BITS-1:0]   mac_result;
   fpfir_pkg::mac_ctl_type                  mac_ctl;

   logic signed [fpfir_pkg::SAMPLE_BITS-1:0] cell_sample [fpfir_pkg::MAX_TAPS];
   logic signed [fpfir_pkg::COEF_BITS-1:0]   cell_coef   [fpfir_pkg::MAX_TAPS];

   // Request handshake
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign sample_fire   = req_fire && (req_bus.kind == fpfir_pkg::KIND_SAMPLE);
   assign coef_fire     = req_fire && (req_bus.kind == fpfir_pkg::KIND_COEF);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Configuration writes
   always_comb begin
      taps_in  = taps_ff;
      shift_in = shift_ff;
      if (csr_we) begin
         unique case (csr_index)
            fpfir_pkg::REG_TAPS_IN_USE:  taps_in  = csr_wdata[fpfir_pkg::TAPS_CFG_BITS-1:0];
            fpfir_pkg::REG_RESULT_SHIFT: shift_in = csr_wdata[fpfir_pkg::SHIFT_CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the tap count to one .. MAX_TAPS
   always_comb begin
      if (taps_ff == '0) begin
         taps_eff = fpfir_pkg::TAP_BITS'(1);
      end else if (int'(taps_ff) > fpfir_pkg::MAX_TAPS) begin
         taps_eff = fpfir_pkg::TAP_BITS'(fpfir_pkg::MAX_TAPS);
      end else begin
         taps_eff = fpfir_pkg::TAP_BITS'(taps_ff);
      end
   end

   // Sequencer: rotate the ring once, drain the last product, then deliver
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_FINAL;
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_FINAL && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = mac_result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         taps_ff      <= fpfir_pkg::TAPS_RESET;
         shift_ff     <= fpfir_pkg::SHIFT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         taps_ff      <= taps_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.filtered = rsp_data_ff;

   // Ring of tap cells: shift right on a sample, rotate left during the sum
   for (genvar i = 0; i < fpfir_pkg::MAX_TAPS; i++) begin : g_cell
      fpfir_pkg::cell_ctl_type                  ctl;
      logic signed [fpfir_pkg::SAMPLE_BITS-1:0] left_sample;

      assign ctl.shift   = sample_fire;
      assign ctl.rotate  = (state_ff == ST_RUN);
      assign ctl.coef_we = coef_fire && (int'(req_bus.coef_index) == i);

      if (i == 0) begin : g_head
         assign left_sample = req_bus.sample_value;
      end else begin : g_body
         assign left_sample = cell_sample[i-1];
      end

      fpfir_tap_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .left_sample  (left_sample),
         .right_sample (cell_sample[(i + 1) % fpfir_pkg::MAX_TAPS]),
         .right_coef   (cell_coef[(i + 1) % fpfir_pkg::MAX_TAPS]),
         .new_coef     (req_bus.coef_value),
         .sample_out   (cell_sample[i]),
         .coef_out     (cell_coef[i])
      );
   end

   // Multiply-accumulate at the head of the ring
   assign mac_ctl.clear  = sample_fire;
   assign mac_ctl.tap_en = (state_ff == ST_RUN) &&
                           (fpfir_pkg::TAP_BITS'(cnt_ff) < taps_eff);

   fpfir_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .ctl          (mac_ctl),
      .sample       (cell_sample[0]),
      .coef         (cell_coef[0]),
      .shift_amount (shift_ff),
      .result       (mac_result)
   );

   // Checks
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> (cnt_ff == '0))
      else $error("tap counter moved outside the run phase");

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> (state_ff == ST_RUN))
      else $error("sample request did not start a run");

   a_final_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished sum was not delivered");

   a_mac_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !u_mac.prod_en_ff)
      else $error("product pending while idle");

endmodule

/* verif/tb_fixed_point_fir_filter.sv */
// Self-checking testbench for the fixed-point FIR filter: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_fixed_point_fir_filter;
   import fpfir_pkg::*;

   localparam int     SETTLE_CYCLES    = MAX_TAPS + 8;
   localparam int     RANDOM_PER_PHASE = 150;
   localparam int     RELOAD_LIMIT     = 24;
   localparam int     REPORT_LIMIT     = 200;
   localparam longint OUT_HI           = (longint'(1) <<< (OUT_BITS - 1)) - 1;
   localparam longint OUT_LO           = -OUT_HI - 1;

   // Predicts the filter output for every accepted sample request and checks responses in order
   class fir_output_checker;
      logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
      logic signed [COEF_BITS-1:0]   coefs [MAX_TAPS];
      int unsigned                   newest;
      logic [TAPS_CFG_BITS-1:0]      tap_count;
      logic [SHIFT_CFG_BITS-1:0]     shift_amount;
      logic signed [OUT_BITS-1:0]    expected_filtered [$];
      int unsigned                   errors;
      int unsigned                   samples;
      int unsigned                   coef_writes;
      int unsigned                   checked;

      function new();
         foreach (history[i]) begin
            history[i] = '0;
            coefs[i]   = '0;
         end
         newest       = 0;
         tap_count    = TAPS_RESET;
         shift_amount = SHIFT_RESET;
         errors       = 0;
         samples      = 0;
         coef_writes  = 0;
         checked      = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
         if (index == REG_TAPS_IN_USE) begin
            tap_count = data[TAPS_CFG_BITS-1:0];
         end else if (index == REG_RESULT_SHIFT) begin
            shift_amount = data[SHIFT_CFG_BITS-1:0];
         end
      endfunction

      function void note_request(logic kind, logic signed [SAMPLE_BITS-1:0] sample,
                                 logic [COEF_INDEX_BITS-1:0] index,
                                 logic signed [COEF_BITS-1:0] coef);
         int unsigned n;
         int unsigned i;
         longint      acc;
         // coefficient write: store it, no response follows
         if (kind == KIND_COEF) begin
            if (index < MAX_TAPS) begin
               coefs[index] = coef;
            end
            coef_writes++;
            return;
         end
         // clamp the tap count into 1 .. MAX_TAPS
         n = (tap_count == 0) ? 1 : ((tap_count > MAX_TAPS) ? MAX_TAPS : tap_count);
         history[newest] = sample;
         acc = 0;
         for (i = 0; i < n; i++) begin
            acc += longint'(coefs[i]) * longint'(history[(newest + MAX_TAPS - i) % MAX_TAPS]);
         end
         // floor shift, then saturate to the output range
         acc = acc >>> shift_amount;
         if (acc > OUT_HI) begin
            acc = OUT_HI;
         end else if (acc < OUT_LO) begin
            acc = OUT_LO;
         end
         expected_filtered.push_back(acc[OUT_BITS-1:0]);
         newest = (newest + 1) % MAX_TAPS;
         samples++;
      endfunction

      function void check_filtered(logic signed [OUT_BITS-1:0] got);
         logic signed [OUT_BITS-1:0] want;
         if (expected_filtered.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t: filtered result %0d arrived with none expected", $time, got);
            end
            return;
         end
         want = expected_filtered.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t: filtered mismatch: expected %0d, actual %0d", $time, want, got);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_filtered.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   bit   steady = 1'b0;
   int unsigned phases = 0;

   fpfir_req_if req_bus ();
   fpfir_rsp_if rsp_bus ();

   fir_output_checker fir_check = new();

   fixed_point_fir_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         2:       return '1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_BITS-1:0] rand_coef();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(COEF_BITS-1){1'b0}}};
         1:       return {1'b0, {(COEF_BITS-1){1'b1}}};
         2:       return '1;
         default: return COEF_BITS'($urandom);
      endcase
   endfunction

   // Hold one request until accepted, after a random gap unless steady
   task automatic send_request(input logic kind, input logic signed [SAMPLE_BITS-1:0] sample,
                               input logic [COEF_INDEX_BITS-1:0] index,
                               input logic signed [COEF_BITS-1:0] coef);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.sample_value <= sample;
      req_bus.coef_index   <= index;
      req_bus.coef_value   <= coef;
      do @(posedge clock); while (!req_bus.ready);
      fir_check.note_request(kind, sample, index, coef);
   endtask

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample);
      send_request(KIND_SAMPLE, sample, COEF_INDEX_BITS'($urandom), rand_coef());
   endtask

   task automatic send_coef(input logic [COEF_INDEX_BITS-1:0] index,
                            input logic signed [COEF_BITS-1:0] coef);
      send_request(KIND_COEF, rand_sample(), index, coef);
   endtask

   // Drop valid and wait until every expected response is back
   task automatic drain_filter(input int unsigned extra);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (fir_check.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      fir_check.set_register(index, data);
   endtask

   task automatic apply_setting(input int unsigned taps, input int unsigned shift);
      drain_filter(SETTLE_CYCLES);
      write_register(REG_TAPS_IN_USE, CSR_DATA_BITS'(taps));
      write_register(REG_RESULT_SHIFT, CSR_DATA_BITS'(shift));
      phases++;
   endtask

   // Response side: random stalls before each response unless steady, then check it
   initial begin : response_sink
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         fir_check.check_filtered(rsp_bus.filtered);
      end
   end

   // Stimulus: directed corners, then random phases over several settings
   initial begin : stimulus
      int unsigned phase_taps [10];
      int unsigned phase_shift [10];
      int unsigned p;
      int unsigned k;
      int unsigned reload;

      phase_taps  = '{1, 64, 2, 17, 64, 33, 0, 100, 49, 127};
      phase_shift = '{0, 31, 14, 9, 15, 16, 12, 13, 13, 20};

      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= REG_TAPS_IN_USE;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.kind         <= KIND_SAMPLE;
      req_bus.sample_value <= '0;
      req_bus.coef_index   <= '0;
      req_bus.coef_value   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty coefficient store gives zero, then edge taps
      send_sample(16'sd12345);
      send_coef(0, 15'sd16383);
      send_coef(1, -15'sd1);
      send_coef(48, -15'sd16384);
      send_coef(63, -15'sd16384);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(-16'sd1);
      send_sample(16'sd0);

      // tap count above the maximum, no shift: drive into saturation
      apply_setting(127, 0);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);
      send_sample(16'sd1);

      // tap count zero acts as one tap, widest shift
      apply_setting(0, 31);
      send_sample(-16'sd32768);
      send_sample(16'sd32767);
      send_sample(-16'sd1);

      // full tap count reaches the oldest history entry
      apply_setting(64, 13);
      send_coef(63, 15'sd16383);
      send_sample(-16'sd32768);
      send_sample(16'sd32767);

      // random phases: load a coefficient set, then mostly samples
      for (p = 0; p < 10; p++) begin
         apply_setting(phase_taps[p], phase_shift[p]);
         reload = (phase_taps[p] > RELOAD_LIMIT) ? RELOAD_LIMIT : phase_taps[p];
         for (k = 0; k < reload; k++) begin
            send_coef(COEF_INDEX_BITS'(k), rand_coef());
         end
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            if ($urandom_range(0, 39) == 0) begin
               steady = !steady;
            end
            if ($urandom_range(0, 199) == 0) begin
               drain_filter(0);
            end
            if ($urandom_range(0, 99) < 20) begin
               send_coef(COEF_INDEX_BITS'($urandom_range(0, MAX_TAPS - 1)), rand_coef());
            end else begin
               send_sample(rand_sample());
            end
         end
      end

      drain_filter(SETTLE_CYCLES);

      $display("Run covered %0d samples and %0d coefficient writes over %0d settings,",
               fir_check.samples, fir_check.coef_writes, phases + 1);
      $display("tap counts 0 to 127 and shifts 0 to 31; %0d responses checked, %0d errors.",
               fir_check.checked, fir_check.errors);
      if (fir_check.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: stop a hung run
   initial begin : watchdog
      #(12_000_000);
      $display("%0t: timeout, %0d responses still outstanding", $time, fir_check.pending());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* filelist.f */
hdl/fpfir_pkg.sv
hdl/fpfir_if.sv
hdl/fpfir_tap_cell.sv
hdl/fpfir_mac.sv
hdl/fixed_point_fir_filter.sv
verif/tb_fixed_point_fir_filter.sv
